// File: hw/rtl/bsc_pkg.sv
// Shared types, constants and helper functions of the safety-check arbiter.
// Depends on nothing; bankers_safety_check and bsc_core use it by scoped names.
`default_nettype none
package bsc_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int MAX_RESOURCES = 8;
   localparam int COUNT_WIDTH   = 16;
   localparam int PROC_W  = $clog2(MAX_PROCESSES);
   localparam int RES_W   = $clog2(MAX_RESOURCES);
   localparam int ADDR_W  = PROC_W + RES_W;
   localparam int PCNT_W  = $clog2(MAX_PROCESSES + 1);
   localparam int RCNT_W  = $clog2(MAX_RESOURCES + 1);
   localparam int TABLE_DEPTH = MAX_PROCESSES * MAX_RESOURCES;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam logic [1:0] MODE_TOTAL   = 2'd0;
   localparam logic [1:0] MODE_MAX     = 2'd1;
   localparam logic [1:0] MODE_ALLOC   = 2'd2;
   localparam logic [1:0] MODE_REQUEST = 2'd3;

   localparam logic [1:0] ST_SAFE   = 2'd0;
   localparam logic [1:0] ST_NEED   = 2'd1;
   localparam logic [1:0] ST_AVAIL  = 2'd2;
   localparam logic [1:0] ST_UNSAFE = 2'd3;

   localparam logic REG_PCOUNT = 1'b0;
   localparam logic REG_RCOUNT = 1'b1;

   typedef struct packed {
      logic [1:0]        mode;
      logic [PROC_W-1:0] process;
      logic [RES_W-1:0]  resource;
      count_type         amount;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              seq_valid;
      logic [PROC_W-1:0] seq_process;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [PCNT_W-1:0] pcount;
      logic [RCNT_W-1:0] rcount;
   } cfg_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_NEED, S_AVAIL, S_GRANT, S_PICK, S_FIT, S_UPD,
      S_ADV, S_ROLLBACK, S_EMIT
   } state_type;

   function automatic count_type sat_sub(input count_type a, input count_type b);
      sat_sub = (a > b) ? a - b : '0;
   endfunction

   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bankers_safety_check.sv
// A load request or a non-final request element is stored while the block stays idle.
// A final element runs the need scan, the available scan, the trial grant and up to P
// safety passes, with a rollback when unsafe, then one result per cycle (P = process
// count in use); a failed need or available check or an out-of-range process skips to it.
// Throughput is one request at a time: busy stays high until the last result is issued.
// After reset the tables are cleared with busy high; results never stall.
`default_nettype none
module bankers_safety_check (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bsc_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output bsc_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);
   localparam int NW = bsc_pkg::PCNT_W;
   localparam int CW = bsc_pkg::RCNT_W;

   // Configuration registers, clamped into their legal ranges on write.
   logic [NW-1:0] pcount_ff, pcount_in;
   logic [CW-1:0] rcount_ff, rcount_in;
   bsc_pkg::cfg_type cfg;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= NW'(bsc_pkg::MAX_PROCESSES);
         rcount_ff <= CW'(bsc_pkg::MAX_RESOURCES);
      end else begin
         pcount_ff <= pcount_in;
         rcount_ff <= rcount_in;
      end
   end

   always_comb begin
      pcount_in = pcount_ff;
      rcount_in = rcount_ff;
      if (psel && penable && pwrite) begin
         case (paddr[2])
            bsc_pkg::REG_PCOUNT: begin
               if (pwdata[NW-1:0] == '0) begin
                  pcount_in = NW'(1);
               end else if (pwdata[NW-1:0] > NW'(bsc_pkg::MAX_PROCESSES)) begin
                  pcount_in = NW'(bsc_pkg::MAX_PROCESSES);
               end else begin
                  pcount_in = pwdata[NW-1:0];
               end
            end
            default: begin
               if (pwdata[CW-1:0] == '0) begin
                  rcount_in = CW'(1);
               end else if (pwdata[CW-1:0] > CW'(bsc_pkg::MAX_RESOURCES)) begin
                  rcount_in = CW'(bsc_pkg::MAX_RESOURCES);
               end else begin
                  rcount_in = pwdata[CW-1:0];
               end
            end
         endcase
      end
   end

   // Reads return the register selected by the address.
   always_comb begin
      case (paddr[2])
         bsc_pkg::REG_PCOUNT: prdata = 32'(pcount_ff);
         default:             prdata = 32'(rcount_ff);
      endcase
   end

   assign cfg.pcount = pcount_ff;
   assign cfg.rcount = rcount_ff;

   // The core holds the tables and runs every check on its shared scan unit.
   bsc_core u_core (
      .clock(clock), .reset(reset), .cfg(cfg),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// File: hw/rtl/bsc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module bsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/bsc_core.sv
// Sequencer and datapath of the safety check: table RAMs, work vector, scans.
// Depends on bsc_pkg and bsc_ram.
`default_nettype none
module bsc_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bsc_pkg::cfg_type cfg,
   input  wire logic             start,
   output logic                  busy,
   input  wire bsc_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output bsc_pkg::rsp_type      rsp_data
);
   localparam int PW = bsc_pkg::PROC_W;
   localparam int RW = bsc_pkg::RES_W;
   localparam int NW = bsc_pkg::PCNT_W;
   localparam int AW = bsc_pkg::ADDR_W;
   localparam int NP = bsc_pkg::MAX_PROCESSES;
   localparam int NR = bsc_pkg::MAX_RESOURCES;

   bsc_pkg::state_type state_ff, state_in;
   logic [PW-1:0] i_ff, i_in, c_ff, c_in, reqp_ff, reqp_in, pp_ff, pp_in, e_ff, e_in;
   logic iss_ff, iss_in, v_ff, v_in, prog_ff, prog_in, fits_ff, fits_in;
   logic seqm_ff, seqm_in;
   logic [RW-1:0] ar_ff, ar_in;
   bsc_pkg::count_type acc_ff, acc_in;
   bsc_pkg::count_type buf_ff [NR], buf_in [NR];
   bsc_pkg::count_type work_ff [NR], work_in [NR];
   bsc_pkg::count_type total_ff [NR], total_in [NR];
   logic [NP-1:0] fin_ff, fin_in;
   logic [PW-1:0] seq_ff [NP], seq_in [NP];
   logic [NW-1:0] len_ff, len_in;
   logic [1:0] stat_ff, stat_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic rsp_strobe_in;
   bsc_pkg::rsp_type rsp_data_in;

   logic [AW-1:0] raddr, waddr;
   bsc_pkg::count_type wdata, mdata, adata, need_c, a_new;
   logic we_max, we_alloc;
   logic [NW-1:0] lim_m1;
   logic last_iss, last_con;
   logic [RW-1:0] ci;
   logic fit_now;

   bsc_ram #(.WIDTH(bsc_pkg::COUNT_WIDTH), .DEPTH(bsc_pkg::TABLE_DEPTH)) u_max (
      .clock(clock), .we(we_max), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(mdata)
   );
   bsc_ram #(.WIDTH(bsc_pkg::COUNT_WIDTH), .DEPTH(bsc_pkg::TABLE_DEPTH)) u_alloc (
      .clock(clock), .we(we_alloc), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(adata)
   );

   function automatic logic RCNT_EQ(input logic [RW-1:0] r);
      RCNT_EQ = (bsc_pkg::RCNT_W'(r) == cfg.rcount - bsc_pkg::RCNT_W'(1));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bsc_pkg::S_CLEAR;
         clr_ff     <= '0;
         iss_ff     <= 1'b0;
         v_ff       <= 1'b0;
         rsp_strobe <= 1'b0;
         fin_ff     <= '0;
         for (int k = 0; k < NR; k++) begin
            total_ff[k] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         iss_ff     <= iss_in;
         v_ff       <= v_in;
         rsp_strobe <= rsp_strobe_in;
         fin_ff     <= fin_in;
         total_ff   <= total_in;
      end
      i_ff     <= i_in;
      c_ff     <= c_in;
      reqp_ff  <= reqp_in;
      pp_ff    <= pp_in;
      e_ff     <= e_in;
      prog_ff  <= prog_in;
      fits_ff  <= fits_in;
      seqm_ff  <= seqm_in;
      ar_ff    <= ar_in;
      acc_ff   <= acc_in;
      buf_ff   <= buf_in;
      work_ff  <= work_in;
      seq_ff   <= seq_in;
      len_ff   <= len_in;
      stat_ff  <= stat_in;
      rsp_data <= rsp_data_in;
   end

   assign busy     = (state_ff != bsc_pkg::S_IDLE);
   assign lim_m1   = (state_ff == bsc_pkg::S_AVAIL) ? cfg.pcount - NW'(1)
                                                    : NW'(cfg.rcount) - NW'(1);
   assign last_iss = (NW'(i_ff) == lim_m1);
   assign last_con = (NW'(c_ff) == lim_m1);
   assign ci       = c_ff[RW-1:0];
   assign need_c   = bsc_pkg::sat_sub(mdata, adata);
   assign a_new    = bsc_pkg::sat_sub(acc_ff, adata);
   assign fit_now  = fits_ff & ~(need_c > work_ff[ci]);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; c_in = c_ff; iss_in = iss_ff; v_in = 1'b0;
      reqp_in = reqp_ff; pp_in = pp_ff; e_in = e_ff;
      prog_in = prog_ff; fits_in = fits_ff; seqm_in = seqm_ff;
      ar_in = ar_ff; acc_in = acc_ff;
      buf_in = buf_ff; work_in = work_ff; total_in = total_ff;
      fin_in = fin_ff; seq_in = seq_ff; len_in = len_ff; stat_in = stat_ff;
      clr_in = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in = rsp_data;
      raddr = {reqp_ff, i_ff[RW-1:0]};
      waddr = {reqp_ff, ci};
      wdata = adata;
      we_max = 1'b0;
      we_alloc = 1'b0;

      // Scan pipeline: issue one table address a cycle, consume its data in the cycle after.
      if (iss_ff) begin
         v_in = 1'b1;
         c_in = i_ff;
         if (last_iss) begin
            iss_in = 1'b0;
         end else begin
            i_in = i_ff + PW'(1);
         end
      end

      case (state_ff)
         bsc_pkg::S_CLEAR: begin
            iss_in = 1'b0; v_in = 1'b0;
            waddr = clr_ff;
            wdata = '0;
            we_max = 1'b1;
            we_alloc = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = bsc_pkg::S_IDLE;
            end
         end
         bsc_pkg::S_IDLE: begin
            iss_in = 1'b0; v_in = 1'b0;
            waddr = {req_data.process, req_data.resource};
            wdata = req_data.amount;
            if (start) begin
               case (req_data.mode)
                  bsc_pkg::MODE_TOTAL: total_in[req_data.resource] = req_data.amount;
                  bsc_pkg::MODE_MAX:   we_max = 1'b1;
                  bsc_pkg::MODE_ALLOC: we_alloc = 1'b1;
                  default: begin
                     buf_in[req_data.resource] = req_data.amount;
                     if (req_data.last) begin
                        reqp_in = req_data.process;
                        if (NW'(req_data.process) >= cfg.pcount) begin
                           stat_in = bsc_pkg::ST_NEED;
                           seqm_in = 1'b0;
                           state_in = bsc_pkg::S_EMIT;
                        end else begin
                           i_in = '0; iss_in = 1'b1;
                           state_in = bsc_pkg::S_NEED;
                        end
                     end
                  end
               endcase
            end
         end
         bsc_pkg::S_NEED: begin
            if (v_ff) begin
               if (buf_ff[ci] > need_c) begin
                  stat_in = bsc_pkg::ST_NEED;
                  seqm_in = 1'b0;
                  iss_in = 1'b0; v_in = 1'b0;
                  state_in = bsc_pkg::S_EMIT;
               end else if (last_con) begin
                  ar_in = '0;
                  acc_in = total_ff[0];
                  i_in = '0; iss_in = 1'b1; v_in = 1'b0;
                  state_in = bsc_pkg::S_AVAIL;
               end
            end
         end
         bsc_pkg::S_AVAIL: begin
            raddr = {i_ff, ar_ff};
            if (v_ff) begin
               acc_in = a_new;
               if (last_con) begin
                  work_in[ar_ff] = a_new;
                  v_in = 1'b0;
                  if (buf_ff[ar_ff] > a_new) begin
                     stat_in = bsc_pkg::ST_AVAIL;
                     seqm_in = 1'b0;
                     state_in = bsc_pkg::S_EMIT;
                  end else if (RCNT_EQ(ar_ff)) begin
                     i_in = '0; iss_in = 1'b1;
                     state_in = bsc_pkg::S_GRANT;
                  end else begin
                     ar_in = ar_ff + RW'(1);
                     acc_in = total_ff[ar_ff + RW'(1)];
                     i_in = '0; iss_in = 1'b1;
                  end
               end
            end
         end
         bsc_pkg::S_GRANT: begin
            if (v_ff) begin
               we_alloc = 1'b1;
               wdata = adata + buf_ff[ci];
               // Avail after the trial grant is the avail before it less the request.
               work_in[ci] = work_ff[ci] - buf_ff[ci];
               if (last_con) begin
                  fin_in = '0; len_in = '0; pp_in = '0; prog_in = 1'b0;
                  state_in = bsc_pkg::S_PICK;
               end
            end
         end
         bsc_pkg::S_PICK: begin
            if (fin_ff[pp_ff]) begin
               state_in = bsc_pkg::S_ADV;
            end else begin
               fits_in = 1'b1;
               i_in = '0; iss_in = 1'b1;
               state_in = bsc_pkg::S_FIT;
            end
         end
         bsc_pkg::S_FIT: begin
            raddr = {pp_ff, i_ff[RW-1:0]};
            if (v_ff) begin
               fits_in = fit_now;
               if (last_con) begin
                  if (fit_now) begin
                     i_in = '0; iss_in = 1'b1;
                     state_in = bsc_pkg::S_UPD;
                  end else begin
                     state_in = bsc_pkg::S_ADV;
                  end
               end
            end
         end
         bsc_pkg::S_UPD: begin
            raddr = {pp_ff, i_ff[RW-1:0]};
            if (v_ff) begin
               work_in[ci] = bsc_pkg::sat_add(work_ff[ci], adata);
               if (last_con) begin
                  fin_in[pp_ff] = 1'b1;
                  seq_in[len_ff[PW-1:0]] = pp_ff;
                  len_in = len_ff + NW'(1);
                  prog_in = 1'b1;
                  state_in = bsc_pkg::S_ADV;
               end
            end
         end
         bsc_pkg::S_ADV: begin
            if (NW'(pp_ff) == cfg.pcount - NW'(1)) begin
               if (!prog_ff || len_ff == cfg.pcount) begin
                  if (len_ff == cfg.pcount) begin
                     stat_in = bsc_pkg::ST_SAFE;
                     seqm_in = 1'b1;
                     e_in = '0;
                     state_in = bsc_pkg::S_EMIT;
                  end else begin
                     i_in = '0; iss_in = 1'b1;
                     state_in = bsc_pkg::S_ROLLBACK;
                  end
               end else begin
                  pp_in = '0;
                  prog_in = 1'b0;
                  state_in = bsc_pkg::S_PICK;
               end
            end else begin
               pp_in = pp_ff + PW'(1);
               state_in = bsc_pkg::S_PICK;
            end
         end
         bsc_pkg::S_ROLLBACK: begin
            if (v_ff) begin
               we_alloc = 1'b1;
               wdata = adata - buf_ff[ci];
               if (last_con) begin
                  stat_in = bsc_pkg::ST_UNSAFE;
                  seqm_in = 1'b0;
                  state_in = bsc_pkg::S_EMIT;
               end
            end
         end
         bsc_pkg::S_EMIT: begin
            iss_in = 1'b0; v_in = 1'b0;
            rsp_strobe_in = 1'b1;
            if (seqm_ff) begin
               rsp_data_in.status      = bsc_pkg::ST_SAFE;
               rsp_data_in.seq_valid   = 1'b1;
               rsp_data_in.seq_process = seq_ff[e_ff];
               rsp_data_in.last_result = (NW'(e_ff) == len_ff - NW'(1));
               e_in = e_ff + PW'(1);
               if (NW'(e_ff) == len_ff - NW'(1)) begin
                  state_in = bsc_pkg::S_IDLE;
               end
            end else begin
               rsp_data_in.status      = stat_ff;
               rsp_data_in.seq_valid   = 1'b0;
               rsp_data_in.seq_process = '0;
               rsp_data_in.last_result = 1'b1;
               state_in = bsc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsc_pkg::S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire
